[design/evm_pkg.sv]
`timescale 1ns / 1ps
package evm_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // pi/2 in Q30 and one in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  // Taylor terms per series and the sine/cosine pipeline depth
  localparam int NUM_TERMS = 8;
  localparam int SC_LAT    = 3 * NUM_TERMS + 3;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // values that ride along the series pipeline
  typedef struct packed {
    logic [31:0]        th2;
    logic signed [33:0] ss;
    logic signed [33:0] sc;
    quad_t              quad;
  } series_t;

endpackage

[design/evm_sincos.sv]
`timescale 1ns / 1ps
module evm_sincos
  import evm_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ANGLE_BITS-1:0]            angle,
  output logic signed [COEF_FRAC_BITS+1:0] sin_out,
  output logic signed [COEF_FRAC_BITS+1:0] cos_out
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int SH = 30 - COEF_FRAC_BITS;
  localparam logic [31:0] RND = (32'd1 << SH) >> 1;

  logic [31:0] a32;
  logic [60:0] theta_prod;
  logic [30:0] theta;
  quad_t       quad1;
  logic [61:0] theta_sq;

  logic [31:0] ts      [0:NUM_TERMS];
  logic [31:0] tc      [0:NUM_TERMS];
  series_t     carry_c [0:NUM_TERMS];
  series_t     carry_a [1:NUM_TERMS];
  series_t     carry_b [1:NUM_TERMS];
  logic [31:0] xs_a    [1:NUM_TERMS];
  logic [31:0] xc_a    [1:NUM_TERMS];
  logic [31:0] xs_b    [1:NUM_TERMS];
  logic [31:0] xc_b    [1:NUM_TERMS];
  logic [31:0] qs_b    [1:NUM_TERMS];
  logic [31:0] qc_b    [1:NUM_TERMS];

  logic signed [CW-1:0] s_mag, c_mag;

  function automatic logic [CW-1:0] to_coef(input logic signed [33:0] v);
    logic [31:0] c;
    logic [31:0] sh_v;
    if (v < 34'sd0) begin
      c = 32'd0;
    end else if (v > $signed({2'b00, ONE_Q30})) begin
      c = ONE_Q30;
    end else begin
      c = v[31:0];
    end
    sh_v = (c + RND) >> SH;
    return sh_v[CW-1:0];
  endfunction

  assign a32        = {angle, {(32 - ANGLE_BITS){1'b0}}};
  assign theta_prod = {31'd0, a32[29:0]} * {30'd0, HALF_PI_Q30};
  assign theta_sq   = {31'd0, theta} * {31'd0, theta};

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= theta_prod[60:30];
      quad1 <= quad_t'(a32[31:30]);
      ts[0] <= {1'b0, theta};
      tc[0] <= ONE_Q30;
      carry_c[0].th2  <= theta_sq[61:30];
      carry_c[0].ss   <= $signed({3'b000, theta});
      carry_c[0].sc   <= $signed({2'b00, ONE_Q30});
      carry_c[0].quad <= quad1;
    end
  end

  for (genvar k = 1; k <= NUM_TERMS; k++) begin : g_term
    localparam logic [31:0] DS = 32'((2 * k) * (2 * k + 1));
    localparam logic [31:0] DC = 32'((2 * k - 1) * (2 * k));
    localparam logic [31:0] MS = 32'((64'd1 << 32) / ((2 * k) * (2 * k + 1)));
    localparam logic [31:0] MC = 32'((64'd1 << 32) / ((2 * k - 1) * (2 * k)));

    logic [63:0] ps, pc, ms, mc;
    logic [31:0] rs, rc, qs, qc;

    assign ps = {32'd0, ts[k-1]} * {32'd0, carry_c[k-1].th2};
    assign pc = {32'd0, tc[k-1]} * {32'd0, carry_c[k-1].th2};
    assign ms = {32'd0, xs_a[k]} * {32'd0, MS};
    assign mc = {32'd0, xc_a[k]} * {32'd0, MC};

    // reciprocal estimate is low by at most two
    assign rs = xs_b[k] - qs_b[k] * DS;
    assign rc = xc_b[k] - qc_b[k] * DC;
    assign qs = (rs >= (DS << 1)) ? qs_b[k] + 32'd2 :
                (rs >= DS)        ? qs_b[k] + 32'd1 : qs_b[k];
    assign qc = (rc >= (DC << 1)) ? qc_b[k] + 32'd2 :
                (rc >= DC)        ? qc_b[k] + 32'd1 : qc_b[k];

    always_ff @(posedge clk) begin
      if (en) begin
        xs_a[k]    <= ps[61:30];
        xc_a[k]    <= pc[61:30];
        carry_a[k] <= carry_c[k-1];
        xs_b[k]    <= xs_a[k];
        xc_b[k]    <= xc_a[k];
        qs_b[k]    <= ms[63:32];
        qc_b[k]    <= mc[63:32];
        carry_b[k] <= carry_a[k];
        ts[k]      <= qs;
        tc[k]      <= qc;
        carry_c[k].th2  <= carry_b[k].th2;
        carry_c[k].quad <= carry_b[k].quad;
        if (k % 2 == 1) begin
          carry_c[k].ss <= carry_b[k].ss - $signed({2'b00, qs});
          carry_c[k].sc <= carry_b[k].sc - $signed({2'b00, qc});
        end else begin
          carry_c[k].ss <= carry_b[k].ss + $signed({2'b00, qs});
          carry_c[k].sc <= carry_b[k].sc + $signed({2'b00, qc});
        end
      end
    end
  end

  assign s_mag = to_coef(carry_c[NUM_TERMS].ss);
  assign c_mag = to_coef(carry_c[NUM_TERMS].sc);

  always_ff @(posedge clk) begin
    if (en) begin
      case (carry_c[NUM_TERMS].quad)
        QUAD_0: begin
          sin_out <= s_mag;
          cos_out <= c_mag;
        end
        QUAD_1: begin
          sin_out <= c_mag;
          cos_out <= -s_mag;
        end
        QUAD_2: begin
          sin_out <= -s_mag;
          cos_out <= -c_mag;
        end
        default: begin
          sin_out <= -c_mag;
          cos_out <= s_mag;
        end
      endcase
    end
  end

endmodule

[design/euler_view_matrix.sv]
`timescale 1ns / 1ps
// Each pose passes through the sine/cosine pipeline, the product stages, the matrix stage and the output registers.
// Throughput: one pose per cycle while the output is not stalled; the Taylor sine/cosine pipeline
// (3 stages per term) and the product stages all advance together on a single enable.
// A stall on the output holds every stage; nothing is dropped or repeated.
// Reset (rst, synchronous) clears only the valid bits; data registers are not reset.
module euler_view_matrix
  import evm_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pitch_angle, yaw_angle, roll_angle, pos_x, pos_y, pos_z
  input  logic [((3 * ANGLE_BITS + 96 + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // trans_0, trans_1, trans_2
  output logic [((9 * (COEF_FRAC_BITS + 2) + 96 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int F   = COEF_FRAC_BITS;
  localparam int CW  = F + 2;
  localparam int A   = ANGLE_BITS;
  localparam int LAT = SC_LAT + 5;
  localparam int TW  = CW + 35;
  localparam logic signed [2*CW-1:0] RNDP = {{(2*CW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [TW-1:0]   RNDT = {{(TW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [CW:0]     C_ONE = {{CW{1'b0}}, 1'b1} << F;
  localparam logic signed [CW:0]     C_MONE = -C_ONE;

  logic           en;
  logic [LAT-1:0] vld;

  logic signed [CW-1:0] sp, cp, sy, cy, sr, cr;
  logic signed [31:0]   pos_d [0:SC_LAT+2][0:2];

  // first product stage
  logic signed [CW-1:0] p_cycr, p_cysr, p_cysp, p_cycp, p_sysp, p_sycp;
  logic signed [CW-1:0] p_cpsr, p_cpcr, p_spsr, p_spcr, p_sy, p_sr, p_cr;
  // second product stage
  logic signed [CW-1:0] q_syspcr, q_syspsr, q_sycpcr, q_sycpsr;
  logic signed [CW-1:0] q_cycr, q_cysr, q_cysp, q_cycp, q_cpsr, q_cpcr;
  logic signed [CW-1:0] q_spsr, q_spcr, q_sy;
  // matrix stage and the two after it
  logic signed [CW-1:0] m_rot [0:8];
  logic signed [CW-1:0] d_rot [0:8];
  logic signed [CW-1:0] o_rot [0:8];
  logic signed [CW+31:0] tprod [0:8];
  logic signed [31:0]    o_trans [0:2];
  logic signed [31:0]    trans_next [0:2];
  logic signed [CW:0]    m_raw [0:8];

  function automatic logic signed [CW-1:0] cmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    p = (p + RNDP) >>> F;
    return p[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_coef(input logic signed [CW:0] v);
    logic signed [CW:0] r;
    if (v > C_ONE) begin
      r = C_ONE;
    end else if (v < C_MONE) begin
      r = C_MONE;
    end else begin
      r = v;
    end
    return r[CW-1:0];
  endfunction

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  evm_sincos #(.ANGLE_BITS(A), .COEF_FRAC_BITS(F)) u_pitch (
    .clk(clk), .en(en), .angle(s_tdata[A-1:0]), .sin_out(sp), .cos_out(cp)
  );
  evm_sincos #(.ANGLE_BITS(A), .COEF_FRAC_BITS(F)) u_yaw (
    .clk(clk), .en(en), .angle(s_tdata[2*A-1:A]), .sin_out(sy), .cos_out(cy)
  );
  evm_sincos #(.ANGLE_BITS(A), .COEF_FRAC_BITS(F)) u_roll (
    .clk(clk), .en(en), .angle(s_tdata[3*A-1:2*A]), .sin_out(sr), .cos_out(cr)
  );

  // position waits beside the angle pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      pos_d[0][0] <= s_tdata[3*A+31:3*A];
      pos_d[0][1] <= s_tdata[3*A+63:3*A+32];
      pos_d[0][2] <= s_tdata[3*A+95:3*A+64];
      for (int i = 1; i <= SC_LAT + 2; i++) begin
        pos_d[i] <= pos_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cycr <= cmul(cy, cr);
      p_cysr <= cmul(cy, sr);
      p_cysp <= cmul(cy, sp);
      p_cycp <= cmul(cy, cp);
      p_sysp <= cmul(sy, sp);
      p_sycp <= cmul(sy, cp);
      p_cpsr <= cmul(cp, sr);
      p_cpcr <= cmul(cp, cr);
      p_spsr <= cmul(sp, sr);
      p_spcr <= cmul(sp, cr);
      p_sy   <= sy;
      p_sr   <= sr;
      p_cr   <= cr;

      q_syspcr <= cmul(p_sysp, p_cr);
      q_syspsr <= cmul(p_sysp, p_sr);
      q_sycpcr <= cmul(p_sycp, p_cr);
      q_sycpsr <= cmul(p_sycp, p_sr);
      q_cycr   <= p_cycr;
      q_cysr   <= p_cysr;
      q_cysp   <= p_cysp;
      q_cycp   <= p_cycp;
      q_cpsr   <= p_cpsr;
      q_cpcr   <= p_cpcr;
      q_spsr   <= p_spsr;
      q_spcr   <= p_spcr;
      q_sy     <= p_sy;
    end
  end

  always_comb begin
    m_raw[0] = {q_cycr[CW-1], q_cycr};
    m_raw[1] = {q_cysr[CW-1], q_cysr};
    m_raw[2] = {q_sy[CW-1], q_sy};
    m_raw[3] = -({q_syspcr[CW-1], q_syspcr} + {q_cpsr[CW-1], q_cpsr});
    m_raw[4] = {q_cpcr[CW-1], q_cpcr} - {q_syspsr[CW-1], q_syspsr};
    m_raw[5] = {q_cysp[CW-1], q_cysp};
    m_raw[6] = {q_spsr[CW-1], q_spsr} - {q_sycpcr[CW-1], q_sycpcr};
    m_raw[7] = -({q_sycpsr[CW-1], q_sycpsr} + {q_spcr[CW-1], q_spcr});
    m_raw[8] = {q_cycp[CW-1], q_cycp};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        m_rot[i] <= sat_coef(m_raw[i]);
        d_rot[i] <= m_rot[i];
        o_rot[i] <= d_rot[i];
        tprod[i] <= m_rot[i] * pos_d[SC_LAT+2][i % 3];
      end
      for (int j = 0; j < 3; j++) begin
        o_trans[j] <= trans_next[j];
      end
    end
  end

  // sum, negate, round and clamp to the signed 32-bit range
  always_comb begin
    logic signed [TW-1:0] acc;
    logic signed [TW-1:0] r;
    for (int j = 0; j < 3; j++) begin
      acc = {{3{tprod[3*j][CW+31]}},   tprod[3*j]}
          + {{3{tprod[3*j+1][CW+31]}}, tprod[3*j+1]}
          + {{3{tprod[3*j+2][CW+31]}}, tprod[3*j+2]};
      r = (-acc + RNDT) >>> F;
      if (r > $signed({{(CW+4){1'b0}}, 31'h7FFF_FFFF})) begin
        trans_next[j] = 32'sh7FFF_FFFF;
      end else if (r < $signed({{(CW+4){1'b1}}, 31'd0})) begin
        trans_next[j] = 32'sh8000_0000;
      end else begin
        trans_next[j] = r[31:0];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      m_tdata[i*CW +: CW] = o_rot[i];
    end
    for (int j = 0; j < 3; j++) begin
      m_tdata[9*CW + 32*j +: 32] = o_trans[j];
    end
  end

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_rot10_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed({o_rot[3][CW-1], o_rot[3]}) <= C_ONE) &&
                 ($signed({o_rot[3][CW-1], o_rot[3]}) >= C_MONE))
    else $error("matrix entry outside unit range");

  a_rot21_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed({o_rot[7][CW-1], o_rot[7]}) <= C_ONE) &&
                 ($signed({o_rot[7][CW-1], o_rot[7]}) >= C_MONE))
    else $error("matrix entry outside unit range");

endmodule

[dv/euler_view_matrix_tb.sv]
`timescale 1ns / 1ps
module euler_view_matrix_tb;
  import evm_pkg::*;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int FB = COEF_FRAC_BITS_DEF;
  localparam int RW = FB + 2;
  localparam int IN_W = ((3 * AB + 96 + 7) / 8) * 8;
  localparam int OUT_W = ((9 * RW + 96 + 7) / 8) * 8;
  localparam int LAT = SC_LAT + 5;

  typedef struct packed {
    logic signed [31:0] t2;
    logic signed [31:0] t1;
    logic signed [31:0] t0;
    logic [8:0][RW-1:0] rot;
  } pose_mat_t;

  // floor division by 2^sh of a signed value
  function automatic longint fl_shift(longint x, int sh);
    return x >>> sh;
  endfunction

  function automatic longint rnd_shift(longint x, int sh);
    return fl_shift(x + (longint'(1) << (sh - 1)), sh);
  endfunction

  function automatic longint cprod(longint a, longint b);
    return rnd_shift(a * b, FB);
  endfunction

  function automatic longint clamp_coef(longint v);
    longint one;
    one = longint'(1) << FB;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint q30_coef(longint v);
    if (v < 0) v = 0;
    if (v > (longint'(1) << 30)) v = longint'(1) << 30;
    return rnd_shift(v, 30 - FB);
  endfunction

  function automatic void sin_cos(input logic [AB-1:0] ang, output longint sn,
                                  output longint cs);
    logic [31:0] a32;
    logic [1:0] quad;
    longint unsigned t, theta, th2, ts, tc, n;
    longint ss, sc, s, c;
    a32 = {ang, {(32 - AB){1'b0}}};
    quad = a32[31:30];
    t = a32[29:0];
    theta = (t * 64'd1686629713) >> 30;
    th2 = (theta * theta) >> 30;
    ts = theta; tc = 64'd1 << 30;
    ss = theta; sc = longint'(1) << 30;
    for (int k = 1; k <= 8; k++) begin
      n = 2 * k;
      ts = ((ts * th2) >> 30) / (n * (n + 1));
      tc = ((tc * th2) >> 30) / ((n - 1) * n);
      if (k % 2 == 1) begin
        ss -= longint'(ts); sc -= longint'(tc);
      end else begin
        ss += longint'(ts); sc += longint'(tc);
      end
    end
    s = q30_coef(ss);
    c = q30_coef(sc);
    case (quad_t'(quad))
      QUAD_0: begin sn = s; cs = c; end
      QUAD_1: begin sn = c; cs = -s; end
      QUAD_2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic signed [31:0] neg_dot(longint r0, longint r1, longint r2,
                                                 longint px, longint py, longint pz);
    longint r;
    r = rnd_shift(-(r0 * px + r1 * py + r2 * pz), FB);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic void view_matrix(input logic [IN_W-1:0] d, output pose_mat_t res);
    longint sp, cp, sy, cy, sr, cr, px, py, pz;
    longint m[9];
    sin_cos(d[AB-1:0], sp, cp);
    sin_cos(d[2*AB-1:AB], sy, cy);
    sin_cos(d[3*AB-1:2*AB], sr, cr);
    px = longint'($signed(d[3*AB +: 32]));
    py = longint'($signed(d[3*AB+32 +: 32]));
    pz = longint'($signed(d[3*AB+64 +: 32]));
    m[0] = cprod(cy, cr);
    m[1] = cprod(cy, sr);
    m[2] = sy;
    m[3] = -(cprod(cprod(sy, sp), cr) + cprod(cp, sr));
    m[4] = cprod(cp, cr) - cprod(cprod(sy, sp), sr);
    m[5] = cprod(cy, sp);
    m[6] = cprod(sp, sr) - cprod(cprod(sy, cp), cr);
    m[7] = -(cprod(cprod(sy, cp), sr) + cprod(sp, cr));
    m[8] = cprod(cy, cp);
    for (int i = 0; i < 9; i++) begin
      m[i] = clamp_coef(m[i]);
      res.rot[i] = m[i][RW-1:0];
    end
    res.t0 = neg_dot(m[0], m[1], m[2], px, py, pz);
    res.t1 = neg_dot(m[3], m[4], m[5], px, py, pz);
    res.t2 = neg_dot(m[6], m[7], m[8], px, py, pz);
  endfunction

  class matrix_scoreboard;
    pose_mat_t pending[$];
    int errors = 0;

    function void note_pose(logic [IN_W-1:0] d);
      pose_mat_t e;
      view_matrix(d, e);
      pending.push_back(e);
    endfunction

    function void check_matrix(logic [OUT_W-1:0] d);
      pose_mat_t e, a;
      a = d[$bits(pose_mat_t)-1:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (e.rot[i] !== a.rot[i]) begin
          $display("%0t: rot[%0d] expected %0d actual %0d", $time, i,
                   $signed(e.rot[i]), $signed(a.rot[i]));
          errors++;
        end
      if (e.t0 !== a.t0 || e.t1 !== a.t1 || e.t2 !== a.t2) begin
        $display("%0t: trans expected %0d %0d %0d actual %0d %0d %0d", $time,
                 e.t0, e.t1, e.t2, a.t0, a.t1, a.t2);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int src_idle = 6;
  int dst_idle = 75;
  bit hold_off = 1'b0;
  matrix_scoreboard sb = new();

  always #1 clk = ~clk;

  euler_view_matrix u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_pose(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_matrix(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= dst_idle);
  end

  task automatic send_pose(input logic [AB-1:0] p, y, r, input logic [31:0] x, yy, z);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, yy, x, r, y, p};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(65536 * 8) - 65536 * 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [AB-1:0] rand_ang();
    case ($urandom_range(4))
      0: return AB'($urandom_range(3)) << (AB - 2);
      1: return (AB'($urandom_range(3)) << (AB - 2)) + AB'($urandom_range(4)) - AB'(2);
      default: return AB'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      send_pose(rand_ang(), rand_ang(), rand_ang(), rand_pos(), rand_pos(), rand_pos());
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners: quadrant edges, extreme angles and positions
    send_pose(0, 0, 0, 0, 0, 0);
    send_pose(16'hffff, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pose(16'h4000, 16'h8000, 16'hc000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pose(16'h8000, 16'hc000, 16'h4000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_pose(16'hc000, 16'h4000, 16'h8000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    send_pose(16'h3fff, 16'h7fff, 16'hbfff, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_pose(16'h2000, 16'h2000, 16'h2000, 32'hffff_ffff, 32'h0000_0001, 32'h5555_5555);
    send_pose(16'h0001, 16'h1555, 16'haaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0001);
    send_pose(16'h5555, 16'haaaa, 16'h0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_pose(16'h4000, 16'h4000, 16'h4000, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f);
    run_random(210);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (LAT * 4) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random(60);
    join
    src_idle = 75; dst_idle = 6;
    run_random(180);
    src_idle = 0; dst_idle = 0;
    run_random(180);
    s_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LAT + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("euler_view_matrix_tb passed");
    else $display("euler_view_matrix_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("euler_view_matrix_tb failed");
    $finish;
  end

endmodule

[euler_view_matrix.f]
design/evm_pkg.sv
design/evm_sincos.sv
design/euler_view_matrix.sv
dv/euler_view_matrix_tb.sv
